@@ hw/rtl/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// Session token table package
// Shared constants, table entry layout, sorter control and sequencer states.
// ----------------------------------------------------------------------------
package stt_pkg;

   localparam int USERS_DEFAULT = 8;
   localparam int TOKW          = 32;
   localparam int STW           = 6;
   localparam int REQ_DW        = 64;
   localparam int RSP_DW        = 32;

   localparam logic [7:0] MINUTES_PER_HOUR = 8'd60;
   localparam logic [4:0] CUR_LIMIT        = 5'd5;
   localparam logic [4:0] PREV_LIMIT       = 5'd10;

   localparam logic [1:0] MODE_TICK   = 2'd0;
   localparam logic [1:0] MODE_LOOKUP = 2'd1;
   localparam logic [1:0] MODE_ISSUE  = 2'd2;

   typedef struct packed {
      logic [TOKW-1:0] tok_prev;
      logic [STW-1:0]  stamp_prev;
      logic [TOKW-1:0] tok_cur;
      logic [STW-1:0]  stamp_cur;
   } entry_type;

   typedef struct packed {
      logic            clr;
      logic            ins;
      logic            pop;
      logic [TOKW-1:0] value;
   } sort_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_GEN,
      ST_WRITE,
      ST_RESP
   } state_type;

   // Minute age with wrap at one hour; a negative age never counts as old.
   function automatic logic is_old(input logic [STW-1:0] stamp,
                                   input logic [STW-1:0] minute,
                                   input logic [4:0] limit);
      logic signed [8:0] age;
      if (stamp > minute) begin
         age = signed'({1'b0, MINUTES_PER_HOUR}) - signed'({3'b000, stamp})
               + signed'({3'b000, minute});
      end else begin
         age = signed'({3'b000, minute}) - signed'({3'b000, stamp});
      end
      return age > signed'({4'b0000, limit});
   endfunction

endpackage

@@ hw/rtl/stt_mem.sv @@
// ----------------------------------------------------------------------------
// Session token table memory
// One entry per user holding both token slots and stamps. Synchronous read
// with a registered output; per-entry valid bits make unwritten tokens zero.
// ----------------------------------------------------------------------------
module stt_mem #(
   parameter int USERS = stt_pkg::USERS_DEFAULT,
   parameter int AW    = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output stt_pkg::entry_type rd_data,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  stt_pkg::entry_type wr_data
);
   import stt_pkg::*;

   entry_type        mem_ff [USERS];
   logic [USERS-1:0] vld_ff;
   entry_type        rd_q_ff;
   logic             rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   always_comb begin
      rd_data = rd_q_ff;
      if (!rd_vld_ff) begin
         rd_data.tok_cur  = '0;
         rd_data.tok_prev = '0;
      end
   end

endmodule

@@ hw/rtl/stt_sorter.sv @@
// ----------------------------------------------------------------------------
// Session token sorter
// A row of cells that keeps inserted tokens in ascending order, one insert
// per cycle, pops the smallest from the head and can be cleared.
// ----------------------------------------------------------------------------
module stt_sorter #(
   parameter int DEPTH = 2 * stt_pkg::USERS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  stt_pkg::sort_ctl_type     ctl,
   output logic                      head_valid,
   output logic [stt_pkg::TOKW-1:0]  head_value
);
   import stt_pkg::*;

   logic [TOKW-1:0]  cell_ff [DEPTH];
   logic [TOKW-1:0]  cell_in [DEPTH];
   logic [TOKW-1:0]  cell_up [DEPTH];
   logic [TOKW-1:0]  cell_dn [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [DEPTH-1:0] vld_in;
   logic [DEPTH-1:0] lt;
   logic [DEPTH-1:0] lt_up;
   logic [DEPTH-1:0] vld_up;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         lt[i] = vld_ff[i] && (cell_ff[i] <= ctl.value);
      end
      lt_up  = {lt[DEPTH-2:0], 1'b1};
      vld_up = {vld_ff[DEPTH-2:0], 1'b1};
      cell_up[0]       = ctl.value;
      cell_dn[DEPTH-1] = '0;
      for (int i = 1; i < DEPTH; i++) begin
         cell_up[i]   = cell_ff[i-1];
         cell_dn[i-1] = cell_ff[i];
      end
   end

   always_comb begin
      cell_in = cell_ff;
      vld_in  = vld_ff;
      priority if (ctl.clr) begin
         vld_in = '0;
      end else if (ctl.ins) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (lt[i]) begin
               cell_in[i] = cell_ff[i];
            end else if (lt_up[i]) begin
               cell_in[i] = ctl.value;
            end else begin
               cell_in[i] = cell_up[i];
            end
         end
         vld_in = vld_ff | vld_up;
      end else if (ctl.pop) begin
         cell_in = cell_dn;
         vld_in  = {1'b0, vld_ff[DEPTH-1:1]};
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign head_valid = vld_ff[0];
   assign head_value = cell_ff[0];

endmodule

@@ hw/rtl/session_token_table_with_aging_unit.sv @@
// ----------------------------------------------------------------------------
// Session token table with aging
// Keeps a current and a previous session token with minute stamps per user;
// ages them on a minute tick, looks tokens up and issues new ones.
// ----------------------------------------------------------------------------
// Every beat reads all 2*USERS slots of the table memory, one slot per cycle
// through its single read port; the result of a beat is loaded into the result
// register from ST_RESP, and only then is the next request beat accepted.
// When a lookup or an issue has to create a token, the new value is walked up
// through the sorted stored tokens one step per cycle. One result beat is
// produced for every request beat; the result register holds it while a new
// request is being worked on.
module session_token_table_with_aging_unit #(
   parameter int USERS = stt_pkg::USERS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // current_minute[5:0], token[37:6], user[40:38], random_draw[60:41]
   input  logic [stt_pkg::REQ_DW-1:0] req_tdata,
   // mode[1:0]
   input  logic [1:0]                 req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // token_out[31:0]
   output logic [stt_pkg::RSP_DW-1:0] rsp_tdata,
   // found[0], was_previous[1]
   output logic [1:0]                 rsp_tuser
);
   import stt_pkg::*;

   localparam int SLOTS = 2 * USERS;
   localparam int UW    = (USERS > 1) ? $clog2(USERS) : 1;
   localparam int SW    = UW + 1;
   localparam int CW    = SW + 1;

   state_type       state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            dv_ff;
   logic [SW-1:0]   dslot_ff;

   logic [1:0]      mode_ff;
   logic [STW-1:0]  minute_ff;
   logic [TOKW-1:0] token_ff;
   logic [2:0]      user_ff;
   logic [19:0]     draw_ff;

   logic            hit_ff;
   logic            hit_odd_ff;
   entry_type       ent_ff;
   logic [UW-1:0]   tgt_ff;
   logic [TOKW-1:0] t_ff;
   logic            res_found_ff;
   logic            res_prev_ff;
   logic [TOKW-1:0] res_tok_ff;
   logic            gen_need;

   logic            rsp_valid_ff;
   logic [RSP_DW-1:0] rsp_data_ff;
   logic [1:0]      rsp_user_ff;

   logic            req_acc;
   logic            issue;
   logic            last_data;
   logic            rsp_load;
   logic            gen_step;
   logic            user_ok;

   entry_type       rd_data;
   logic            mem_rd_en;
   logic            mem_wr_en;
   logic [UW-1:0]   mem_wr_addr;
   entry_type       mem_wr_data;

   sort_ctl_type    sort_ctl;
   logic            head_valid;
   logic [TOKW-1:0] head_value;

   logic            half;
   logic [UW-1:0]   eidx;
   logic [TOKW-1:0] slot_tok;
   logic            lookup_hit;
   logic            user_sel;
   logic            tick_move;
   logic            tick_clear;
   entry_type       tick_entry;

   stt_mem #(
      .USERS (USERS),
      .AW    (UW)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (cnt_ff[SW-1:1]),
      .rd_data (rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   stt_sorter #(
      .DEPTH (SLOTS)
   ) u_sorter (
      .clock      (clock),
      .reset      (reset),
      .ctl        (sort_ctl),
      .head_valid (head_valid),
      .head_value (head_value)
   );

   // Slot data coming back from the memory.
   assign half       = dslot_ff[0];
   assign eidx       = dslot_ff[SW-1:1];
   assign slot_tok   = half ? rd_data.tok_prev : rd_data.tok_cur;
   assign lookup_hit = dv_ff && (mode_ff == MODE_LOOKUP) && (token_ff != '0)
                       && (slot_tok == token_ff) && !hit_ff;
   assign user_sel   = dv_ff && (mode_ff == MODE_ISSUE) && !half
                       && (7'(user_ff) == 7'(eidx));
   assign user_ok    = 7'(user_ff) < 7'(USERS);
   assign tick_move  = (rd_data.tok_cur != '0)
                       && is_old(rd_data.stamp_cur, minute_ff, CUR_LIMIT);
   assign tick_clear = !tick_move && (rd_data.tok_prev != '0)
                       && is_old(rd_data.stamp_prev, minute_ff, PREV_LIMIT);

   always_comb begin
      tick_entry = rd_data;
      if (tick_move) begin
         tick_entry.tok_prev   = rd_data.tok_cur;
         tick_entry.stamp_prev = rd_data.stamp_cur;
         tick_entry.tok_cur    = '0;
      end else if (tick_clear) begin
         tick_entry.tok_prev = '0;
      end
   end

   assign req_acc   = req_tvalid && req_tready;
   assign issue     = (state_ff == ST_SCAN) && (cnt_ff < CW'(SLOTS));
   assign last_data = dv_ff && (cnt_ff == CW'(SLOTS));
   assign gen_step  = head_valid && (t_ff >= head_value);
   assign rsp_load  = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_tready);
   assign gen_need  = (ent_ff.tok_cur == '0)
                      && (((mode_ff == MODE_LOOKUP) && hit_ff && hit_odd_ff)
                          || ((mode_ff == MODE_ISSUE) && user_ok));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_data) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = gen_need ? ST_GEN : ST_RESP;
         end
         ST_GEN: begin
            if (!gen_step) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready     = 1'b0;
      mem_rd_en      = 1'b0;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = eidx;
      mem_wr_data    = tick_entry;
      sort_ctl.clr   = 1'b0;
      sort_ctl.ins   = 1'b0;
      sort_ctl.pop   = 1'b0;
      sort_ctl.value = slot_tok;
      cnt_in         = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            sort_ctl.clr = req_acc;
            cnt_in       = '0;
         end
         ST_SCAN: begin
            mem_rd_en    = issue;
            sort_ctl.ins = dv_ff && (slot_tok != '0);
            mem_wr_en    = dv_ff && half && (mode_ff == MODE_TICK)
                           && (tick_move || tick_clear);
            if (issue) begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_GEN: begin
            sort_ctl.pop = gen_step;
         end
         ST_WRITE: begin
            mem_wr_en             = 1'b1;
            mem_wr_addr           = tgt_ff;
            mem_wr_data           = ent_ff;
            mem_wr_data.tok_cur   = t_ff;
            mem_wr_data.stamp_cur = minute_ff;
         end
         ST_DECIDE, ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         dv_ff    <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         dv_ff    <= issue;
         if (req_acc) begin
            hit_ff <= 1'b0;
         end else if (lookup_hit) begin
            hit_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dslot_ff <= cnt_ff[SW-1:0];
      if (req_acc) begin
         mode_ff   <= req_tuser;
         minute_ff <= req_tdata[5:0];
         token_ff  <= req_tdata[37:6];
         user_ff   <= req_tdata[40:38];
         draw_ff   <= req_tdata[60:41];
      end
      if (lookup_hit || user_sel) begin
         ent_ff     <= rd_data;
         tgt_ff     <= eidx;
         hit_odd_ff <= half;
      end
      if (state_ff == ST_DECIDE) begin
         t_ff         <= 32'(draw_ff) + 32'd1;
         res_found_ff <= 1'b0;
         res_prev_ff  <= 1'b0;
         res_tok_ff   <= '0;
         if ((mode_ff == MODE_LOOKUP) && hit_ff) begin
            res_found_ff <= 1'b1;
            res_prev_ff  <= hit_odd_ff;
            res_tok_ff   <= hit_odd_ff ? ent_ff.tok_cur : token_ff;
         end else if ((mode_ff == MODE_ISSUE) && user_ok) begin
            res_found_ff <= 1'b1;
            res_tok_ff   <= ent_ff.tok_cur;
         end
      end else if (state_ff == ST_GEN) begin
         if (gen_step) begin
            t_ff <= t_ff + 32'd1;
         end
      end else if (state_ff == ST_WRITE) begin
         res_tok_ff <= t_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= res_tok_ff;
         rsp_user_ff <= {res_prev_ff, res_found_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_write_source: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> ((state_ff == ST_SCAN) && (mode_ff == MODE_TICK))
                    || (state_ff == ST_WRITE))
      else $error("table write outside an aging pass or token creation");

   a_write_after_gen: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> ($past(state_ff) == ST_GEN))
      else $error("token written without a creation walk");

   a_gen_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GEN) |-> (t_ff > 32'(draw_ff)))
      else $error("new token fell below its draw");

   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == ST_SCAN) && (cnt_ff == '0) && !hit_ff)
      else $error("scan did not start clean after a request beat");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Session token table testbench
// Drives tick, lookup, issue and spare-mode beats into the token table and
// checks every response against a behavioral copy of the table kept here.
// Well-formed minute sequences make tokens age and move to the previous
// slot, and lookups mostly use tokens that are held in the table.
// ----------------------------------------------------------------------------
module tb;

   import stt_pkg::*;

   localparam int         USERS      = USERS_DEFAULT;
   localparam int         SLOTS      = 2 * USERS;
   localparam int         DRAW_MAX   = 786384;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [5:0]  minute;
      logic [31:0] tok;
      logic [2:0]  user;
      logic [19:0] draw;
   } sess_req_type;

   typedef struct packed {
      logic        found;
      logic [31:0] tok;
      logic        prev;
   } sess_rsp_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_DW-1:0]   req_tdata  = '0;
   logic [1:0]          req_tuser  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_DW-1:0]   rsp_tdata;
   logic [1:0]          rsp_tuser;

   logic [31:0] tbl_tok [SLOTS];
   logic [5:0]  tbl_stamp [SLOTS];

   sess_req_type req_backlog [$];
   sess_rsp_type pending_replies [$];
   int           req_count  = 0;
   int           sent_count = 0;
   int           err_count  = 0;
   bit           rsp_hold   = 1'b0;
   wire          calm       = (req_count >= 700) && (req_count < 1000);

   session_token_table_with_aging_unit #(.USERS(USERS)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic bit is_stale(input logic [5:0] stamp, input logic [5:0] now,
                                   input int limit);
      int age;
      if (stamp > now) begin
         age = int'(MINUTES_PER_HOUR) - int'(stamp) + int'(now);
      end else begin
         age = int'(now) - int'(stamp);
      end
      return age > limit;
   endfunction

   // A new token starts at draw + 1 and steps past every stored token that
   // it reaches, taken in ascending order.
   function automatic logic [31:0] fresh_token(input logic [19:0] draw);
      logic [31:0] sorted [SLOTS];
      logic [31:0] v;
      logic [31:0] t;
      int          n;
      int          j;
      n = 0;
      t = 32'd1 + 32'(draw);
      for (int i = 0; i < SLOTS; i++) begin
         v = tbl_tok[i];
         if (v != 32'd0) begin
            j = n;
            while (j > 0 && sorted[j-1] > v) begin
               sorted[j] = sorted[j-1];
               j--;
            end
            sorted[j] = v;
            n++;
         end
      end
      for (int i = 0; i < n; i++) begin
         if (t >= sorted[i]) t++;
      end
      return t;
   endfunction

   function automatic sess_rsp_type session_update(input sess_req_type r);
      sess_rsp_type res;
      int           c;
      int           p;
      res = '0;
      case (r.mode)
         MODE_TICK: begin
            for (int u = 0; u < USERS; u++) begin
               c = 2 * u;
               p = c + 1;
               if (tbl_tok[c] != 0 && is_stale(tbl_stamp[c], r.minute, int'(CUR_LIMIT))) begin
                  tbl_tok[p]   = tbl_tok[c];
                  tbl_stamp[p] = tbl_stamp[c];
                  tbl_tok[c]   = 32'd0;
               end else if (tbl_tok[p] != 0 &&
                            is_stale(tbl_stamp[p], r.minute, int'(PREV_LIMIT))) begin
                  tbl_tok[p] = 32'd0;
               end
            end
         end
         MODE_LOOKUP: begin
            if (r.tok != 32'd0) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (tbl_tok[i] == r.tok) begin
                     res.found = 1'b1;
                     if (i % 2 == 0) begin
                        res.tok = r.tok;
                     end else begin
                        res.prev = 1'b1;
                        if (tbl_tok[i-1] == 32'd0) begin
                           tbl_tok[i-1]   = fresh_token(r.draw);
                           tbl_stamp[i-1] = r.minute;
                        end
                        res.tok = tbl_tok[i-1];
                     end
                     break;
                  end
               end
            end
         end
         MODE_ISSUE: begin
            if (int'(r.user) < USERS) begin
               c = 2 * int'(r.user);
               if (tbl_tok[c] == 32'd0) begin
                  tbl_tok[c]   = fresh_token(r.draw);
                  tbl_stamp[c] = r.minute;
               end
               res.tok   = tbl_tok[c];
               res.found = 1'b1;
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   task automatic report_miss(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      err_count++;
      if (err_count <= 10) begin
         $display("mismatch on %s: expected %0h, got %0h (response %0d)", what, want, got,
                  req_count - pending_replies.size());
      end
   endtask

   // Responses are checked before the request of the same edge is predicted.
   sess_rsp_type want_rsp;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_replies.size() == 0) begin
               report_miss("unexpected beat", 32'd0, rsp_tdata);
            end else begin
               want_rsp = pending_replies.pop_front();
               if (rsp_tuser[0] !== want_rsp.found) begin
                  report_miss("found", 32'(want_rsp.found), 32'(rsp_tuser[0]));
               end
               if (rsp_tdata !== want_rsp.tok) begin
                  report_miss("token_out", want_rsp.tok, rsp_tdata);
               end
               if (rsp_tuser[1] !== want_rsp.prev) begin
                  report_miss("was_previous", 32'(want_rsp.prev), 32'(rsp_tuser[1]));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            pending_replies.push_back(session_update(sess_req_type'{req_tuser,
               req_tdata[5:0], req_tdata[37:6], req_tdata[40:38], req_tdata[60:41]}));
            req_count++;
         end
      end
   end

   sess_req_type next_req;

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || sent_count == req_count) begin
         if (req_backlog.size() > 0 && (calm || $urandom_range(0, 99) >= 23)) begin
            next_req = req_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= next_req.mode;
            req_tdata  <= {3'b000, next_req.draw, next_req.user, next_req.tok, next_req.minute};
            sent_count++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= !reset && !rsp_hold && (calm || $urandom_range(0, 99) >= 23);
   end

   initial begin
      wait (req_count >= 1300);
      rsp_hold = 1'b1;
      repeat (400) @(negedge clock);
      rsp_hold = 1'b0;
   end

   task automatic push_req(input logic [1:0] mode, input logic [5:0] minute,
                           input logic [31:0] tok, input logic [2:0] user,
                           input logic [19:0] draw);
      while (req_backlog.size() >= 3) @(posedge clock);
      req_backlog.push_back(sess_req_type'{mode, minute, tok, user, draw});
   endtask

   task automatic settle();
      while (req_backlog.size() != 0 || req_tvalid || pending_replies.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [19:0] any_draw();
      return 20'($urandom_range(0, DRAW_MAX));
   endfunction

   initial begin : stimulus
      logic [5:0]  now;
      logic [31:0] pick;
      int          roll;
      for (int i = 0; i < SLOTS; i++) begin
         tbl_tok[i]   = 32'd0;
         tbl_stamp[i] = 6'd0;
      end
      wait (!reset);

      push_req(MODE_ISSUE, 6'd0, 32'd0, 3'd0, 20'd0);
      push_req(MODE_ISSUE, 6'd59, 32'hFFFFFFFF, 3'd7, 20'(DRAW_MAX));
      push_req(MODE_ISSUE, 6'd1, 32'd0, 3'd0, 20'd5);
      push_req(MODE_LOOKUP, 6'd1, 32'd0, 3'd0, 20'd0);
      push_req(MODE_LOOKUP, 6'd1, 32'hFFFFFFFF, 3'd7, 20'hFFFFF);
      push_req(MODE_SPARE, 6'd63, $urandom, 3'd7, 20'hFFFFF);
      settle();
      push_req(MODE_LOOKUP, 6'd2, tbl_tok[0], 3'd0, 20'd0);
      push_req(MODE_LOOKUP, 6'd2, tbl_tok[SLOTS-2], 3'd0, 20'd0);
      // The user 7 token ages out at minute 5, the user 0 token at minute 6.
      push_req(MODE_TICK, 6'd5, 32'd0, 3'd0, 20'd0);
      push_req(MODE_TICK, 6'd6, 32'd0, 3'd0, 20'd0);
      settle();
      push_req(MODE_LOOKUP, 6'd7, tbl_tok[1], 3'd0, 20'(DRAW_MAX));
      push_req(MODE_LOOKUP, 6'd7, tbl_tok[1], 3'd0, 20'd9);
      push_req(MODE_ISSUE, 6'd7, 32'd0, 3'd7, 20'd0);
      push_req(MODE_TICK, 6'd60, 32'd0, 3'd0, 20'd0);
      push_req(MODE_TICK, 6'd63, 32'd0, 3'd0, 20'd0);
      push_req(MODE_ISSUE, 6'd62, 32'd0, 3'd3, 20'd1);
      push_req(MODE_TICK, 6'd0, 32'd0, 3'd0, 20'd0);
      push_req(MODE_TICK, 6'd2, 32'd0, 3'd0, 20'd0);
      push_req(MODE_TICK, 6'd20, 32'd0, 3'd0, 20'd0);
      push_req(MODE_TICK, 6'd40, 32'd0, 3'd0, 20'd0);
      settle();

      now = 6'd40;
      for (int n = 0; n < 2000; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 12) begin
            now = 6'((int'(now) + $urandom_range(0, 3)) % 60);
            push_req(MODE_TICK, now, $urandom, 3'($urandom), any_draw());
         end else if (roll < 45) begin
            push_req(MODE_ISSUE, now, $urandom, 3'($urandom), any_draw());
         end else if (roll < 85) begin
            pick = tbl_tok[$urandom_range(0, SLOTS - 1)];
            if (pick == 32'd0) pick = tbl_tok[$urandom_range(0, SLOTS - 1)];
            if ($urandom_range(0, 9) == 0) pick = pick + 32'd1;
            push_req(MODE_LOOKUP, now, pick, 3'($urandom), any_draw());
         end else if (roll < 93) begin
            push_req(MODE_LOOKUP, now, ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom,
                     3'($urandom), any_draw());
         end else if (roll < 97) begin
            push_req(MODE_SPARE, 6'($urandom), $urandom, 3'($urandom), any_draw());
         end else begin
            push_req(2'($urandom_range(0, 2)), 6'($urandom), $urandom, 3'($urandom),
                     any_draw());
         end
      end

      settle();
      repeat (60) @(posedge clock);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
